// File: src/first_fit_chunk_allocator_top_assert.svh
// Assertion macros for the first-fit chunk allocator.
`ifndef FIRST_FIT_CHUNK_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_CHUNK_ALLOCATOR_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define FFA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define FFA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: src/ffca_pkg.sv
// Shared types and codes for the first-fit chunk allocator.
package ffca_pkg;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [8:0] {
    S_INIT   = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_SCAN   = 9'b000000100,
    S_DECIDE = 9'b000001000,
    S_FRMV   = 9'b000010000,
    S_UINS   = 9'b000100000,
    S_FINS   = 9'b001000000,
    S_URMV   = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;
endpackage

// File: src/first_fit_chunk_allocator_top.sv
// First-fit chunk allocator with sorted free and used chunk tables.
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid/in_tready   | in_tuser=mode, in_tdata=size,address
//  out_    | out | out_tvalid/out_tready | out_tdata=granted_address,status
// One request at a time; every table walk moves one entry per cycle.
// Reset (synchronous, active low), then the init state writes the heap-size chunk.
// The result waits in a register; a stalled out_tready holds off the next request.
module first_fit_chunk_allocator_top
  import ffca_pkg::*;
#(
  parameter int HEAP_BYTES    = 65536,
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [0:0]  in_tuser,   // mode
  input  logic [39:0] in_tdata,   // request_size[16:0], block_address[32:17], zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // granted_address[15:0], status[17:16], zero
);
  `include "first_fit_chunk_allocator_top_assert.svh"

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);
  localparam logic [16:0] HEAP_LEN = 17'(HEAP_BYTES);

  logic [15:0] fs_mem [TABLE_ENTRIES];
  logic [16:0] fl_mem [TABLE_ENTRIES];
  logic [15:0] us_mem [TABLE_ENTRIES];
  logic [16:0] ul_mem [TABLE_ENTRIES];

  state_t        state_r, state_nxt;
  logic [CW-1:0] fcnt_r, fcnt_nxt;
  logic [CW-1:0] ucnt_r, ucnt_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [AW-1:0] ra_r, ra_nxt;
  logic          rv_r, rv_nxt;
  logic          mode_r, mode_nxt;
  logic [16:0]   req_r, req_nxt;
  logic [15:0]   addr_r, addr_nxt;
  logic          found_r, found_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [15:0]   s_r, s_nxt;
  logic [16:0]   n_r, n_nxt;
  logic [15:0]   ins_s_r, ins_s_nxt;
  logic [16:0]   ins_n_r, ins_n_nxt;
  logic [15:0]   granted_r, granted_nxt;
  logic [1:0]    status_r, status_nxt;

  // registered reads, one address per table per cycle
  logic [AW-1:0] rd_a;
  logic [15:0]   f_rs_r, u_rs_r;
  logic [16:0]   f_rl_r, u_rl_r;

  // write ports
  logic          f_we, u_we;
  logic [AW-1:0] f_wa, u_wa;
  logic [15:0]   f_ws, u_ws;
  logic [16:0]   f_wl, u_wl;

  logic [CW-1:0] km1;
  logic [CW-1:0] scan_lim;
  logic          hit;
  logic [15:0]   ins_rd_s;
  logic [16:0]   ins_rd_l;
  logic [AW-1:0] wr_up, wr_dn;
  logic          ins_we, ins_end;
  logic [AW-1:0] ins_wa;
  logic [15:0]   ins_ws;
  logic [16:0]   ins_wl;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {6'd0, status_r, granted_r};

  assign km1      = k_r - CW'(1);
  assign rd_a     = (state_r == S_UINS || state_r == S_FINS) ? km1[AW-1:0] : k_r[AW-1:0];
  assign scan_lim = (mode_r == MODE_FREE) ? ucnt_r : ((req_r == 17'd0) ? '0 : fcnt_r);
  assign hit      = rv_r && ((mode_r == MODE_FREE) ? (u_rs_r == addr_r) : (f_rl_r >= req_r));
  assign ins_rd_s = (state_r == S_UINS) ? u_rs_r : f_rs_r;
  assign ins_rd_l = (state_r == S_UINS) ? u_rl_r : f_rl_r;
  assign wr_up    = ra_r + AW'(1);
  assign wr_dn    = ra_r - AW'(1);

  always_ff @(posedge clk) begin
    if (f_we) begin
      fs_mem[f_wa] <= f_ws;
      fl_mem[f_wa] <= f_wl;
    end
    f_rs_r <= fs_mem[rd_a];
    f_rl_r <= fl_mem[rd_a];
  end

  always_ff @(posedge clk) begin
    if (u_we) begin
      us_mem[u_wa] <= u_ws;
      ul_mem[u_wa] <= u_wl;
    end
    u_rs_r <= us_mem[rd_a];
    u_rl_r <= ul_mem[rd_a];
  end

  always_comb begin
    state_nxt   = state_r;
    fcnt_nxt    = fcnt_r;
    ucnt_nxt    = ucnt_r;
    k_nxt       = k_r;
    ra_nxt      = ra_r;
    rv_nxt      = 1'b0;
    mode_nxt    = mode_r;
    req_nxt     = req_r;
    addr_nxt    = addr_r;
    found_nxt   = found_r;
    idx_nxt     = idx_r;
    s_nxt       = s_r;
    n_nxt       = n_r;
    ins_s_nxt   = ins_s_r;
    ins_n_nxt   = ins_n_r;
    granted_nxt = granted_r;
    status_nxt  = status_r;
    f_we = 1'b0; f_wa = wr_up; f_ws = ins_s_r; f_wl = ins_n_r;
    u_we = 1'b0; u_wa = wr_up; u_ws = ins_s_r; u_wl = ins_n_r;
    ins_we = 1'b0; ins_end = 1'b0; ins_wa = wr_up; ins_ws = ins_s_r; ins_wl = ins_n_r;
    case (state_r)
      S_INIT: begin
        f_we = 1'b1; f_wa = '0; f_ws = 16'd0; f_wl = HEAP_LEN;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          mode_nxt  = in_tuser[0];
          req_nxt   = in_tdata[16:0];
          addr_nxt  = in_tdata[32:17];
          k_nxt     = '0;
          found_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          found_nxt = 1'b1;
          idx_nxt   = ra_r;
          s_nxt     = (mode_r == MODE_FREE) ? u_rs_r : f_rs_r;
          n_nxt     = (mode_r == MODE_FREE) ? u_rl_r : f_rl_r;
          state_nxt = S_DECIDE;
        end else if (k_r < scan_lim) begin
          rv_nxt = 1'b1; ra_nxt = k_r[AW-1:0]; k_nxt = k_r + CW'(1);
        end else if (!rv_r) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        granted_nxt = 16'd0;
        k_nxt = {1'b0, idx_r} + CW'(1);
        if (mode_r == MODE_ALLOC) begin
          if (!found_r) begin
            status_nxt = ST_NOFIT; state_nxt = S_OUT;
          end else if (ucnt_r >= FULL) begin
            status_nxt = ST_FULL; state_nxt = S_OUT;
          end else begin
            status_nxt = ST_OK; granted_nxt = s_r; state_nxt = S_FRMV;
          end
        end else begin
          if (!found_r) begin
            status_nxt = ST_UNKNOWN; state_nxt = S_OUT;
          end else if (fcnt_r >= FULL) begin
            status_nxt = ST_FULL; state_nxt = S_OUT;
          end else begin
            status_nxt = ST_OK;
            ins_s_nxt = s_r; ins_n_nxt = n_r;
            k_nxt = fcnt_r;
            state_nxt = S_FINS;
          end
        end
      end
      // shift free entries above idx down by one
      S_FRMV: begin
        if (rv_r) begin
          f_we = 1'b1; f_wa = wr_dn; f_ws = f_rs_r; f_wl = f_rl_r;
        end
        if (k_r < fcnt_r) begin
          rv_nxt = 1'b1; ra_nxt = k_r[AW-1:0]; k_nxt = k_r + CW'(1);
        end else if (!rv_r) begin
          fcnt_nxt  = fcnt_r - CW'(1);
          ins_s_nxt = s_r; ins_n_nxt = req_r;
          k_nxt     = ucnt_r;
          state_nxt = S_UINS;
        end
      end
      // walk down from the count, shifting larger starts up by one, then write the new entry
      S_UINS, S_FINS: begin
        ins_we = 1'b1;
        if (rv_r && ins_rd_s > ins_s_r) begin
          ins_ws = ins_rd_s; ins_wl = ins_rd_l;
          if (k_r != '0) begin
            rv_nxt = 1'b1; ra_nxt = km1[AW-1:0]; k_nxt = km1;
          end
        end else if (rv_r) begin
          ins_end = 1'b1;
        end else if (k_r == '0) begin
          ins_wa = '0; ins_end = 1'b1;
        end else begin
          ins_we = 1'b0;
          rv_nxt = 1'b1; ra_nxt = km1[AW-1:0]; k_nxt = km1;
        end
        if (state_r == S_UINS) begin
          u_we = ins_we; u_wa = ins_wa; u_ws = ins_ws; u_wl = ins_wl;
        end else begin
          f_we = ins_we; f_wa = ins_wa; f_ws = ins_ws; f_wl = ins_wl;
        end
        if (ins_end) begin
          if (state_r == S_UINS) begin
            ucnt_nxt = ucnt_r + CW'(1);
            if (n_r > req_r) begin
              ins_s_nxt = s_r + req_r[15:0];
              ins_n_nxt = n_r - req_r;
              k_nxt     = fcnt_r;
              state_nxt = S_FINS;
            end else begin
              state_nxt = S_OUT;
            end
          end else begin
            fcnt_nxt = fcnt_r + CW'(1);
            if (mode_r == MODE_FREE) begin
              k_nxt     = {1'b0, idx_r} + CW'(1);
              state_nxt = S_URMV;
            end else begin
              state_nxt = S_OUT;
            end
          end
        end
      end
      // shift used entries above idx down by one
      S_URMV: begin
        if (rv_r) begin
          u_we = 1'b1; u_wa = wr_dn; u_ws = u_rs_r; u_wl = u_rl_r;
        end
        if (k_r < ucnt_r) begin
          rv_nxt = 1'b1; ra_nxt = k_r[AW-1:0]; k_nxt = k_r + CW'(1);
        end else if (!rv_r) begin
          ucnt_nxt  = ucnt_r - CW'(1);
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      fcnt_r    <= CW'(1);
      ucnt_r    <= '0;
      k_r       <= '0;
      ra_r      <= '0;
      rv_r      <= 1'b0;
      mode_r    <= MODE_ALLOC;
      req_r     <= '0;
      addr_r    <= '0;
      found_r   <= 1'b0;
      idx_r     <= '0;
      s_r       <= '0;
      n_r       <= '0;
      ins_s_r   <= '0;
      ins_n_r   <= '0;
      granted_r <= '0;
      status_r  <= ST_OK;
    end else begin
      state_r   <= state_nxt;
      fcnt_r    <= fcnt_nxt;
      ucnt_r    <= ucnt_nxt;
      k_r       <= k_nxt;
      ra_r      <= ra_nxt;
      rv_r      <= rv_nxt;
      mode_r    <= mode_nxt;
      req_r     <= req_nxt;
      addr_r    <= addr_nxt;
      found_r   <= found_nxt;
      idx_r     <= idx_nxt;
      s_r       <= s_nxt;
      n_r       <= n_nxt;
      ins_s_r   <= ins_s_nxt;
      ins_n_r   <= ins_n_nxt;
      granted_r <= granted_nxt;
      status_r  <= status_nxt;
    end
  end

  `FFA_ASSERT_IMP(a_cnt_free, 1'b1, fcnt_r <= FULL, "free count beyond table")
  `FFA_ASSERT_IMP(a_cnt_used, 1'b1, ucnt_r <= FULL, "used count beyond table")
  `FFA_ASSERT_NXT(a_busy, in_tvalid && in_tready, !in_tready, "accepted while busy")
  `FFA_ASSERT_IMP(a_stat, out_tvalid && status_r != ST_OK, granted_r == 16'd0,
    "address on failure")
  `FFA_ASSERT_NXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata),
    "result dropped while stalled")
endmodule
